>>> rtl/c3wf_pkg.sv
// Shared types and constants of the 3x3 window filter.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
package c3wf_pkg;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_WEIGHTS_TOP    = 3'd0;
  localparam logic [2:0] REG_WEIGHTS_MIDDLE = 3'd1;
  localparam logic [2:0] REG_WEIGHTS_BOTTOM = 3'd2;
  localparam logic [2:0] REG_DIVISOR        = 3'd3;
  localparam logic [2:0] REG_LINE_WIDTH     = 3'd4;

  // Signed sum of nine 8u x 8s products fits in 20 bits; a positive one in 19.
  localparam int ACC_W = 20;
  localparam int DIV_W = 19;

  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] MAC_LAST = STEP_W'(8);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_W - 1);

  typedef struct packed {
    logic              accept;    // latch beat, read line store
    logic              shift;     // shift window, write line store
    logic              mac;       // accumulate one product
    logic              prep;      // load divider
    logic              div_step;  // one quotient bit
    logic              out_load;  // load output register
    logic [STEP_W-1:0] step;      // tap select while accumulating
  } cmd_t;

  typedef struct packed {
    logic produce;  // current pixel yields an output
  } status_t;

endpackage

>>> rtl/c3wf_ctrl.sv
// Controller state machine of the 3x3 window filter.
// Depends on c3wf_pkg; drives the datapath through cmd_t.
`timescale 1ns / 1ps
module c3wf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  input  c3wf_pkg::status_t status_i,
  output c3wf_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_MAC   = 3'd2;
  localparam logic [2:0] S_PREP  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]                  state_q, state_d;
  logic [c3wf_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic                        mvalid_q, mvalid_d;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    cmd_o    = '0;
    cmd_o.step = cnt_q;
    s_ready_o = 1'b0;
    mvalid_d = mvalid_q && !m_ready_i;
    case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        cnt_d = '0;
        state_d = status_i.produce ? S_MAC : S_IDLE;
      end
      S_MAC: begin
        cmd_o.mac = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == c3wf_pkg::MAC_LAST) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == c3wf_pkg::DIV_LAST) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!mvalid_q || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          mvalid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      mvalid_q <= mvalid_d;
    end
  end

  assign m_valid_o = mvalid_q;

endmodule

>>> rtl/c3wf_dpath.sv
// Datapath of the 3x3 window filter: line store, window, MAC, divider, output.
// Depends on c3wf_pkg; sequenced by c3wf_ctrl.
`timescale 1ns / 1ps
module c3wf_dpath #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  c3wf_pkg::cmd_t    cmd_i,
  output c3wf_pkg::status_t status_o,
  input  logic [7:0]        pixel_i,
  input  logic              frame_start_i,
  input  logic [23:0]       w_top_i,
  input  logic [23:0]       w_mid_i,
  input  logic [23:0]       w_bot_i,
  input  logic [7:0]        divisor_i,
  input  logic [10:0]       line_width_i,
  output logic [7:0]        filtered_o,
  output logic              row_end_o
);

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int AW = c3wf_pkg::ACC_W;
  localparam int DW = c3wf_pkg::DIV_W;

  logic [7:0]    line0_q [MAX_WIDTH];  // previous row
  logic [7:0]    line1_q [MAX_WIDTH];  // row before that
  logic [7:0]    rd_top_q, rd_mid_q;
  logic [7:0]    win_q [9];            // index row*3 + column
  logic [7:0]    pix_q;
  logic [CW-1:0] col_q, column_q, column_d;
  logic [1:0]    rows_q, rows_d;
  logic          last_q, produce_q;

  int            lw_int, ew_int;
  logic [CW-1:0] ewm1, col_src, col;
  logic          last, produce;
  logic [1:0]    rows_eff;

  always_comb begin
    lw_int = int'(line_width_i);
    if (lw_int < 3) ew_int = 3;
    else if (lw_int > MAX_WIDTH) ew_int = MAX_WIDTH;
    else ew_int = lw_int;
    ewm1     = CW'(ew_int - 1);
    col_src  = frame_start_i ? '0 : column_q;
    col      = (col_src > ewm1) ? ewm1 : col_src;
    last     = (col == ewm1);
    rows_eff = frame_start_i ? 2'd0 : rows_q;
    produce  = (rows_eff == 2'd2) && (col >= CW'(2));
    column_d = last ? '0 : col + 1'b1;
    rows_d   = (last && rows_eff != 2'd2) ? rows_eff + 2'd1 : rows_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      rows_q   <= '0;
    end else if (cmd_i.accept) begin
      column_q <= column_d;
      rows_q   <= rows_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pix_q     <= pixel_i;
      col_q     <= col;
      last_q    <= last;
      produce_q <= produce;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_top_q <= line1_q[col];
      rd_mid_q <= line0_q[col];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      line1_q[col_q] <= rd_mid_q;
      line0_q[col_q] <= pix_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r*3]   <= win_q[r*3+1];
        win_q[r*3+1] <= win_q[r*3+2];
      end
      win_q[2] <= rd_top_q;
      win_q[5] <= rd_mid_q;
      win_q[8] <= pix_q;
    end
  end

  assign status_o.produce = produce_q;

  // Multiply-accumulate, one tap per cycle.
  logic [7:0]           tap_px, tap_w;
  logic signed [16:0]   prod;
  logic signed [AW-1:0] acc_q;

  always_comb begin
    tap_px = win_q[0];
    tap_w  = w_top_i[7:0];
    case (cmd_i.step)
      5'd0: begin tap_px = win_q[0]; tap_w = w_top_i[7:0];   end
      5'd1: begin tap_px = win_q[1]; tap_w = w_top_i[15:8];  end
      5'd2: begin tap_px = win_q[2]; tap_w = w_top_i[23:16]; end
      5'd3: begin tap_px = win_q[3]; tap_w = w_mid_i[7:0];   end
      5'd4: begin tap_px = win_q[4]; tap_w = w_mid_i[15:8];  end
      5'd5: begin tap_px = win_q[5]; tap_w = w_mid_i[23:16]; end
      5'd6: begin tap_px = win_q[6]; tap_w = w_bot_i[7:0];   end
      5'd7: begin tap_px = win_q[7]; tap_w = w_bot_i[15:8];  end
      5'd8: begin tap_px = win_q[8]; tap_w = w_bot_i[23:16]; end
      default: begin tap_px = win_q[0]; tap_w = w_top_i[7:0]; end
    endcase
    prod = $signed({1'b0, tap_px}) * $signed(tap_w);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      acc_q <= '0;
    end else if (cmd_i.mac) begin
      acc_q <= acc_q + AW'(prod);
    end
  end

  // Restoring divider, one quotient bit per cycle.
  logic [DW-1:0] dq_q;
  logic [7:0]    rem_q;
  logic          nonpos_q, divz_q;
  logic [8:0]    trial;
  logic          qbit;

  always_comb begin
    trial = {rem_q, dq_q[DW-1]};
    qbit  = (trial >= {1'b0, divisor_i});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      dq_q     <= acc_q[DW-1:0];
      rem_q    <= '0;
      nonpos_q <= acc_q[AW-1] || (acc_q == '0);
      divz_q   <= (divisor_i == '0);
    end else if (cmd_i.div_step) begin
      rem_q <= qbit ? 8'(trial - {1'b0, divisor_i}) : trial[7:0];
      dq_q  <= {dq_q[DW-2:0], qbit};
    end
  end

  logic [7:0] result;
  always_comb begin
    if (nonpos_q) result = 8'd0;
    else if (divz_q || (|dq_q[DW-1:8])) result = 8'd255;
    else result = dq_q[7:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      filtered_o <= result;
      row_end_o  <= last_q;
    end
  end

endmodule

>>> rtl/conv3x3_window_filter_top.sv
// 3x3 window filter: a pixel is taken only after the previous one has passed the
// line store step and, where it yields output, the nine-tap MAC loop, the
// bit-serial divider and the output load, which waits for a free output register.
// Reset (rst_ni, async low) clears position counters, handshake state and
// the configuration registers; line store and window hold no reset.
`timescale 1ns / 1ps
module conv3x3_window_filter_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream. tdata: pixel[7:0]. tuser: frame_start.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tuser,
  // Output stream. tdata: filtered[7:0]. tlast: row_end.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);

  // Configuration registers. The user must write them only while the filter is
  // idle, which the block does not enforce; the datapath reads them directly.
  logic [23:0] w_top_q, w_mid_q, w_bot_q;
  logic [7:0]  divisor_q;
  logic [10:0] line_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_top_q      <= 24'h010101;
      w_mid_q      <= 24'h010101;
      w_bot_q      <= 24'h010101;
      divisor_q    <= 8'd9;
      line_width_q <= 11'd1024;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        c3wf_pkg::REG_WEIGHTS_TOP:    w_top_q      <= cfg_data_i;
        c3wf_pkg::REG_WEIGHTS_MIDDLE: w_mid_q      <= cfg_data_i;
        c3wf_pkg::REG_WEIGHTS_BOTTOM: w_bot_q      <= cfg_data_i;
        c3wf_pkg::REG_DIVISOR:        divisor_q    <= cfg_data_i[7:0];
        c3wf_pkg::REG_LINE_WIDTH:     line_width_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  c3wf_pkg::cmd_t    cmd;
  c3wf_pkg::status_t status;

  // The controller takes one beat at a time and steps it through line store
  // access and, if it yields output, the multiply-accumulate loop and the divider.
  c3wf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  c3wf_dpath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .pixel_i       (s_axis_tdata),
    .frame_start_i (s_axis_tuser),
    .w_top_i       (w_top_q),
    .w_mid_i       (w_mid_q),
    .w_bot_i       (w_bot_q),
    .divisor_i     (divisor_q),
    .line_width_i  (line_width_q),
    .filtered_o    (m_axis_tdata),
    .row_end_o     (m_axis_tlast)
  );

  // Only one pixel is in flight, so an accepted beat closes the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a pixel is in flight");

  // A result is loaded only for a pixel that produces output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> status.produce)
    else $error("output loaded for a pixel without result");

  // The output register is never overwritten while its beat is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("pending output beat overwritten");

endmodule

>>> tb/conv3x3_window_filter_top_tb.sv
// Self-checking testbench of the 3x3 window filter: pixel stream in, filtered stream out.
// It predicts each output beat from its own copy of the filter state and compares it
// with the block. It depends on c3wf_pkg and conv3x3_window_filter_top.
`timescale 1ns / 1ps
module conv3x3_window_filter_top_tb;

  localparam int MAXW = 1024;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 40;
  // An index past the last register; writes to it must be ignored.
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [7:0] filtered;
    logic       row_end;
  } out_beat_t;

  // One directed row: pixel, frame flag, and, where it is obvious, the result.
  typedef struct {
    logic [7:0] pixel;
    logic       fstart;
    logic       has_known;
    out_beat_t  known;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [23:0] cfg_data_i = '0;

  conv3x3_window_filter_top #(.MAX_WIDTH(MAXW)) dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow of the filter: registers, line store, window and position.
  logic [23:0] w_top = 24'h010101, w_mid = 24'h010101, w_bot = 24'h010101;
  logic [7:0]  div_reg = 8'd9;
  logic [10:0] width_reg = 11'd1024;
  logic [7:0]  lines [2][MAXW];
  logic [7:0]  win [3][3];
  int unsigned col_pos = 0, rows_done = 0;

  out_beat_t pending_q[$];
  int errors = 0, beats_in = 0, beats_out = 0, frames = 0;
  longint cycles = 0;

  bit rx_hold = 1'b0;   // long receiver hold-off requested by the stimulus

  // Mirrors the register write in the filter shadow.
  task automatic shadow_write(input logic [2:0] idx, input logic [23:0] val);
    case (idx)
      c3wf_pkg::REG_WEIGHTS_TOP:    w_top = val;
      c3wf_pkg::REG_WEIGHTS_MIDDLE: w_mid = val;
      c3wf_pkg::REG_WEIGHTS_BOTTOM: w_bot = val;
      c3wf_pkg::REG_DIVISOR:        div_reg = val[7:0];
      c3wf_pkg::REG_LINE_WIDTH:     width_reg = val[10:0];
      default: ;
    endcase
  endtask

  // Advances the shadow by one pixel; returns 1 and the filtered beat when one is due.
  function automatic bit filter_pixel(input logic [7:0] px, input logic fs,
                                      output out_beat_t res);
    int unsigned wd, c;
    logic [7:0] t, m;
    logic [23:0] rows [3];
    int sum, q;
    bit lastc, made;
    wd = width_reg < 3 ? 3 : (width_reg > MAXW ? MAXW : width_reg);
    if (fs) begin
      col_pos = 0;
      rows_done = 0;
    end
    c = col_pos >= wd ? wd - 1 : col_pos;
    t = lines[1][c];
    m = lines[0][c];
    lines[1][c] = m;
    lines[0][c] = px;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = t;
    win[1][2] = m;
    win[2][2] = px;
    lastc = (c == wd - 1);
    made = 0;
    res = '0;
    if (rows_done >= 2 && c >= 2) begin
      rows = '{w_top, w_mid, w_bot};
      sum = 0;
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 3; k++)
          sum += int'(win[r][k]) * int'($signed(rows[r][8*k +: 8]));
      if (div_reg == 0) q = sum > 0 ? 255 : 0;
      else q = sum / int'(div_reg);
      if (q < 0) q = 0;
      if (q > 255) q = 255;
      res.filtered = q[7:0];
      res.row_end = lastc;
      made = 1;
    end
    if (lastc) begin
      col_pos = 0;
      if (rows_done < 2) rows_done++;
    end else begin
      col_pos = c + 1;
    end
    return made;
  endfunction

  // Sends one pixel beat after a random gap and records its expected result.
  // The first edge waited is the one right after the previous beat, where the
  // block is never ready, so a gap of zero still offers the earliest beat.
  task automatic send_pixel(input logic [7:0] px, input logic fs);
    out_beat_t res;
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap + 1) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    s_axis_tuser <= fs;
    do @(posedge clk_i); while (!s_axis_tready);
    s_axis_tvalid <= 1'b0;
    beats_in++;
    if (fs) frames++;
    if (filter_pixel(px, fs, res)) pending_q.push_back(res);
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    shadow_write(idx, val);
  endtask

  // Sends a whole frame of pixels; kind 0 random, 1 extremes, 2 flat.
  task automatic send_frame(input int unsigned w, input int unsigned h, input int kind);
    logic [7:0] px;
    for (int unsigned i = 0; i < w * h; i++) begin
      case (kind)
        1: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        2: px = 8'h80;
        default: px = 8'($urandom_range(0, 255));
      endcase
      send_pixel(px, i == 0);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off when the stimulus asks.
  initial begin
    int stall;
    out_beat_t want;
    @(posedge rst_ni);
    forever begin
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      stall = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        beats_out++;
        if (pending_q.size() == 0) begin
          $error("unexpected output beat: filtered %0d row_end %0d",
                 m_axis_tdata, m_axis_tlast);
          errors++;
        end else begin
          want = pending_q.pop_front();
          if (m_axis_tdata !== want.filtered) begin
            $error("filtered: expected %0d, got %0d", want.filtered, m_axis_tdata);
            errors++;
          end
          if (m_axis_tlast !== want.row_end) begin
            $error("row_end: expected %0d, got %0d", want.row_end, m_axis_tlast);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog on the cycle count.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Directed table: a 4x3 frame of extremes at width 4 with default weights.
  // Rows two on give outputs; all-255 windows divided by 9 give 255.
  dir_row_t dir_tab [12];

  initial begin
    int unsigned w, h;
    bit wide_sent;
    wide_sent = 1'b0;
    for (int i = 0; i < 12; i++) begin
      dir_tab[i].pixel = 8'hFF;
      dir_tab[i].fstart = (i == 0);
      dir_tab[i].has_known = (i >= 10);
      dir_tab[i].known = '{filtered: 8'hFF, row_end: (i == 11)};
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, default registers except the width.
    write_reg(c3wf_pkg::REG_LINE_WIDTH, 24'd4);
    foreach (dir_tab[i]) begin
      send_pixel(dir_tab[i].pixel, dir_tab[i].fstart);
      if (dir_tab[i].has_known && pending_q[$] !== dir_tab[i].known) begin
        $error("table row %0d: predictor disagrees with typed result", i);
        errors++;
      end
    end
    wait_drained();

    // Extreme pixels, then an all-negative kernel that saturates to zero.
    write_reg(c3wf_pkg::REG_LINE_WIDTH, 24'd3);
    send_frame(3, 3, 1);
    wait_drained();
    write_reg(c3wf_pkg::REG_WEIGHTS_TOP, 24'h808080);
    write_reg(c3wf_pkg::REG_WEIGHTS_MIDDLE, 24'h808080);
    write_reg(c3wf_pkg::REG_WEIGHTS_BOTTOM, 24'h808080);
    write_reg(c3wf_pkg::REG_DIVISOR, 24'd1);
    send_frame(3, 3, 2);
    wait_drained();
    // Divisor zero with positive and negative sums, width below minimum.
    write_reg(c3wf_pkg::REG_WEIGHTS_TOP, 24'h7F7F7F);
    write_reg(c3wf_pkg::REG_DIVISOR, 24'd0);
    write_reg(c3wf_pkg::REG_LINE_WIDTH, 24'd0);
    send_frame(3, 4, 0);
    wait_drained();
    // Out-of-range register index is ignored.
    write_reg(REG_UNUSED, 24'hFFFFFF);
    write_reg(c3wf_pkg::REG_WEIGHTS_MIDDLE, 24'hFF01FF);
    write_reg(c3wf_pkg::REG_DIVISOR, 24'd255);
    send_frame(3, 3, 1);
    wait_drained();

    // Back-pressure: the receiver holds off while the sender keeps going.
    write_reg(c3wf_pkg::REG_LINE_WIDTH, 24'd5);
    write_reg(c3wf_pkg::REG_DIVISOR, 24'd3);
    rx_hold = 1'b1;
    send_frame(5, 6, 0);
    wait_drained();

    // Random part: phases with random registers and mostly small frames.
    // One early phase uses an oversized width for a single full-length row.
    while (beats_in < 1950) begin
      write_reg(c3wf_pkg::REG_WEIGHTS_TOP, 24'($urandom_range(0, 24'hFFFFFF)));
      write_reg(c3wf_pkg::REG_WEIGHTS_MIDDLE, 24'($urandom_range(0, 24'hFFFFFF)));
      write_reg(c3wf_pkg::REG_WEIGHTS_BOTTOM, 24'($urandom_range(0, 24'hFFFFFF)));
      write_reg(c3wf_pkg::REG_DIVISOR,
                24'($urandom_range(0, 4) == 0 ? 1 : $urandom_range(0, 255)));
      case ($urandom_range(0, 9))
        0: w = 0;
        1: w = (wide_sent || beats_in > 900) ? 7 : 2047;
        default: w = $urandom_range(3, 12);
      endcase
      if (w == 2047) wide_sent = 1'b1;
      write_reg(c3wf_pkg::REG_LINE_WIDTH, 24'(w));
      w = w < 3 ? 3 : (w > MAXW ? MAXW : w);
      h = w > 100 ? 1 : $urandom_range(3, 7);
      send_frame(w, h, $urandom_range(0, 9) == 0 ? 1 : 0);
      // Now and then a noise pixel or an aborted row before the next frame.
      if ($urandom_range(0, 4) == 0)
        for (int i = $urandom_range(1, 4); i > 0; i--)
          send_pixel(8'($urandom_range(0, 255)), 1'b0);
      wait_drained();
    end

    $display("covered %0d pixel beats in %0d frames, %0d filtered beats checked",
             beats_in, frames, beats_out);
    $display("including extreme weights, divisors zero to 255 and widths 3 to %0d", MAXW);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
